/* rtl/core/csf_pkg.sv */
// Shared types and constants for the template-fit Cash statistic block.
// Used by csf_muldiv, csf_log2 and cash_statistic_template_fit_sum.
package csf_pkg;

  // Widths of the shared arithmetic
  localparam int MD_W   = 64;   // multiply-divide operand width
  localparam int VAL_W  = 48;   // saturated Q32.16 values
  localparam int TOT_W  = 49;   // n*2^16 + m and mu0 + V
  localparam int LMAG_W = 62;   // capped log magnitudes and products
  localparam int YLD_W  = 32;
  localparam int TPL_W  = 40;
  localparam int CNT_W  = 20;
  localparam int BIN_W  = 32;

  localparam int LOG_STEPS_DEF = 24;

  localparam logic [VAL_W-1:0]  SAT48  = {VAL_W{1'b1}};
  localparam logic [MD_W-1:0]   CAP62  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [MD_W-1:0]   LN2_Q32 = 64'd2977044472;
  localparam logic [TPL_W-1:0]  TOTAL_ONE = 40'd65536;
  localparam logic [MD_W-1:0]   Q16_ONE = 64'd65536;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_YIELD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_YIELD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_TOTAL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_TOTAL = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] observed_count;
    logic [BIN_W-1:0] signal_bin;
    logic [BIN_W-1:0] background_bin;
    logic             last_bin;
  } bin_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] q_value;
    logic             overflow;
  } q_out_t;

  // Operands handed to the multiply-divide unit
  typedef struct packed {
    logic            start;
    logic [MD_W-1:0] a;
    logic [MD_W-1:0] b;
    logic [MD_W-1:0] d;
    logic [MD_W-1:0] cap;
  } md_req_t;

endpackage

/* rtl/core/cash_statistic_template_fit_sum.sv */
// Cash statistic with template uncertainty, summed over histogram bins.
// Depends on csf_pkg, csf_muldiv and csf_log2.
//
// Usage:
//   Write the two yields and two template totals on the cfg channel
//   (index 0..3) while the block is idle; cfg_ready is always high.
//   Feed one bin per transfer on the in channel (in_valid / in_stall).
//   Each bin's Cash terms are added to a saturating Q32.16 accumulator.
//   The bin flagged last_bin produces one result transfer on the out
//   channel carrying Q and the saturation flag; the pass then restarts.
// Work per bin:
//   Each multiply-divide runs on the shared bit-serial unit and each
//   log2 on the serial log2 unit. A full bin uses up to 11 multiply-divides
//   and 4 logs; a bin with zero expectation or variance ends after the
//   template multiply-divides. One bin is in work at a time; in_stall is
//   high until it is done.
// Reset clears the accumulator, the flag, out_valid and sets the
//   registers to yields 0 and totals 1.0. A stalled result is held in the
//   output register; the next bins are still taken, and only a following
//   last bin waits for the held result to be transferred.
module cash_statistic_template_fit_sum #(
  parameter int LOG_STEPS = csf_pkg::LOG_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  csf_pkg::bin_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output csf_pkg::q_out_t                   out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csf_pkg::TPL_W-1:0]         cfg_data
);

  localparam int W    = csf_pkg::MD_W;
  localparam int VW   = csf_pkg::VAL_W;
  localparam int TW   = csf_pkg::TOT_W;
  localparam int LW   = LOG_STEPS + 7;
  localparam logic [W-1:0] LN_DIV = W'(1) << (LOG_STEPS + 16);

  typedef enum logic [3:0] {
    S_IDLE, S_U1, S_V1, S_U2, S_V2, S_SUM, S_M, S_E1, S_E2,
    S_TERM, S_LA, S_LB, S_LN, S_PM, S_NXT, S_FIN
  } st_t;

  st_t                        state;
  logic [csf_pkg::YLD_W-1:0]  y1, y2;
  logic [csf_pkg::TPL_W-1:0]  s1, s2;
  logic [VW-1:0]              q_acc;
  logic                       sat;

  logic [csf_pkg::CNT_W-1:0]  n;
  logic [csf_pkg::BIN_W-1:0]  bg;
  logic                       last;
  logic [VW-1:0]              u1, u2, v1, mu0, vr, m;
  logic [TW-1:0]              tot, den, e2, obs, exv;
  logic                       term;
  logic [LW-1:0]              la;
  logic                       neg;

  csf_pkg::md_req_t           md_req;
  logic                       md_done;
  logic [W-1:0]               md_res;
  logic                       lg_start;
  logic [W-1:0]               lg_x;
  logic                       lg_done;
  logic [LW-1:0]              lg_res;

  logic [VW:0]                mu_sum, vr_sum;
  logic [VW-1:0]              mu0_c, vr_c;
  logic [TW-1:0]              nq, tot_c;
  logic [LW:0]                ldiff;
  logic [LW-1:0]              lmag;
  logic signed [W+1:0]        t_c;
  logic [W-1:0]               cash_c;
  logic [W:0]                 acc_sum;

  csf_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .done   (md_done),
    .result (md_res)
  );

  csf_log2 #(.LOG_STEPS(LOG_STEPS)) u_lg (
    .clk    (clk),
    .rst    (rst),
    .start  (lg_start),
    .x_in   (lg_x),
    .done   (lg_done),
    .result (lg_res)
  );

  // Narrow datapath helpers around the shared units
  always_comb begin
    mu_sum = {1'b0, u1} + {1'b0, u2};
    vr_sum = {1'b0, v1} + {1'b0, md_res[VW-1:0]};
    mu0_c  = mu_sum[VW] ? csf_pkg::SAT48 : mu_sum[VW-1:0];
    vr_c   = vr_sum[VW] ? csf_pkg::SAT48 : vr_sum[VW-1:0];
    nq     = TW'({n, 16'h0000});
    tot_c  = nq + TW'(md_res[VW-1:0]);
    ldiff  = {la[LW-1], la} - {lg_res[LW-1], lg_res};
    lmag   = ldiff[LW] ? LW'(-ldiff) : ldiff[LW-1:0];
    t_c    = $signed({2'b00, W'(exv)}) - $signed({2'b00, W'(obs)});
    t_c    = neg ? t_c - $signed({2'b00, md_res}) : t_c + $signed({2'b00, md_res});
    cash_c = (t_c > 0) ? t_c[W-1:0] : '0;
    acc_sum = {1'b0, W'(q_acc)} + {1'b0, cash_c};
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      y1        <= '0;
      y2        <= '0;
      s1        <= csf_pkg::TOTAL_ONE;
      s2        <= csf_pkg::TOTAL_ONE;
      q_acc     <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
      md_req.start <= 1'b0;
      lg_start  <= 1'b0;
    end else begin
      md_req.start <= 1'b0;
      lg_start     <= 1'b0;

      // register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          csf_pkg::CFG_SIGNAL_YIELD:     y1 <= cfg_data[csf_pkg::YLD_W-1:0];
          csf_pkg::CFG_BACKGROUND_YIELD: y2 <= cfg_data[csf_pkg::YLD_W-1:0];
          csf_pkg::CFG_SIGNAL_TOTAL:     s1 <= cfg_data;
          csf_pkg::CFG_BACKGROUND_TOTAL: s2 <= cfg_data;
          default: ;
        endcase
      end

      // drop the result once transferred
      if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            n    <= in_data.observed_count;
            bg   <= in_data.background_bin;
            last <= in_data.last_bin;
            u1   <= '0;
            v1   <= '0;
            u2   <= '0;
            if (s1 != '0) begin
              md_req <= '{1'b1, W'(y1), W'(in_data.signal_bin), W'(s1), W'(csf_pkg::SAT48)};
              state  <= S_U1;
            end else if (s2 != '0) begin
              md_req <= '{1'b1, W'(y2), W'(in_data.background_bin), W'(s2),
                          W'(csf_pkg::SAT48)};
              state  <= S_U2;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_U1: if (md_done) begin
          u1     <= md_res[VW-1:0];
          md_req <= '{1'b1, W'(y1), md_res, W'(s1), W'(csf_pkg::SAT48)};
          state  <= S_V1;
        end
        S_V1: if (md_done) begin
          v1 <= md_res[VW-1:0];
          if (s2 != '0) begin
            md_req <= '{1'b1, W'(y2), W'(bg), W'(s2), W'(csf_pkg::SAT48)};
            state  <= S_U2;
          end else begin
            state <= S_SUM;
          end
        end
        S_U2: if (md_done) begin
          u2     <= md_res[VW-1:0];
          md_req <= '{1'b1, W'(y2), md_res, W'(s2), W'(csf_pkg::SAT48)};
          state  <= S_V2;
        end
        S_V2: if (md_done) begin
          v1    <= vr_c;   // fold v2 in now: v1 holds the summed variance
          state <= S_SUM;
        end
        S_SUM: begin
          mu0 <= mu0_c;
          vr  <= v1;
          if (mu0_c == '0 || v1 == '0) begin
            state <= S_FIN;
          end else begin
            md_req <= '{1'b1, W'(mu0_c), W'(mu0_c), W'(v1), W'(csf_pkg::SAT48)};
            state  <= S_M;
          end
        end
        S_M: if (md_done) begin
          m      <= md_res[VW-1:0];
          tot    <= tot_c;
          den    <= TW'(vr) + TW'(mu0);
          md_req <= '{1'b1, W'(tot_c), W'(vr), W'(TW'(vr) + TW'(mu0)), W'(tot_c)};
          state  <= S_E1;
        end
        S_E1: if (md_done) begin
          obs    <= nq;
          exv    <= md_res[TW-1:0];
          term   <= 1'b0;
          md_req <= '{1'b1, W'(tot), W'(mu0), W'(den), W'(tot)};
          state  <= S_E2;
        end
        S_E2: if (md_done) begin
          e2    <= md_res[TW-1:0];
          state <= S_TERM;
        end
        S_TERM: begin
          if (obs == '0 || exv == '0) begin
            state <= S_NXT;
          end else begin
            lg_start <= 1'b1;
            lg_x     <= W'(obs);
            state    <= S_LA;
          end
        end
        S_LA: if (lg_done) begin
          la       <= lg_res;
          lg_start <= 1'b1;
          lg_x     <= W'(exv);
          state    <= S_LB;
        end
        S_LB: if (lg_done) begin
          neg    <= ldiff[LW];
          md_req <= '{1'b1, W'(lmag), csf_pkg::LN2_Q32, LN_DIV, csf_pkg::CAP62};
          state  <= S_LN;
        end
        S_LN: if (md_done) begin
          md_req <= '{1'b1, W'(obs), md_res, csf_pkg::Q16_ONE, csf_pkg::CAP62};
          state  <= S_PM;
        end
        // add one Cash term, saturating
        S_PM: if (md_done) begin
          if (acc_sum > {{(W+1-VW){1'b0}}, csf_pkg::SAT48}) begin
            q_acc <= csf_pkg::SAT48;
            sat   <= 1'b1;
          end else begin
            q_acc <= acc_sum[VW-1:0];
          end
          state <= S_NXT;
        end
        S_NXT: begin
          if (!term) begin
            term  <= 1'b1;
            obs   <= TW'(m);
            exv   <= e2;
            state <= S_TERM;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (!out_valid || !out_stall) begin
            out_data.q_value  <= q_acc;
            out_data.overflow <= sat;
            out_valid         <= 1'b1;
            q_acc             <= '0;
            sat               <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/csf_muldiv.sv */
// Bit-serial floor(a*b/d) limited to cap: shift-add multiply, then restoring divide.
// Depends on csf_pkg.
module csf_muldiv (
  input  logic                          clk,
  input  logic                          rst,
  input  csf_pkg::md_req_t              req,
  output logic                          done,
  output logic [csf_pkg::MD_W-1:0]      result
);

  localparam int W     = csf_pkg::MD_W;
  localparam int CW    = $clog2(2 * W);
  localparam logic [CW-1:0] MUL_LAST = CW'(W - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(2 * W - 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} md_state_t;

  md_state_t      state;
  logic [W-1:0]   hi, lo, a_r, d_r, cap_r, rem, q;
  logic           ovf;
  logic [CW-1:0]  cnt;

  logic [W:0]     mul_sum;
  logic [W:0]     rem_sh;
  logic           q_bit;

  // One multiplier bit and one quotient bit per cycle
  always_comb begin
    mul_sum = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : {(W+1){1'b0}});
    rem_sh  = {rem, hi[W-1]};
    q_bit   = (rem_sh >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            hi    <= '0;
            lo    <= req.b;
            a_r   <= req.a;
            d_r   <= req.d;
            cap_r <= req.cap;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          hi  <= mul_sum[W:1];
          lo  <= {mul_sum[0], lo[W-1:1]};
          cnt <= cnt + 1'b1;
          if (cnt == MUL_LAST) begin
            cnt   <= '0;
            rem   <= '0;
            q     <= '0;
            ovf   <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          hi  <= {hi[W-2:0], lo[W-1]};
          lo  <= {lo[W-2:0], 1'b0};
          rem <= q_bit ? W'(rem_sh - {1'b0, d_r}) : rem_sh[W-1:0];
          ovf <= ovf | q[W-1];
          q   <= {q[W-2:0], q_bit};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) state <= S_FIN;
        end
        S_FIN: begin
          result <= (ovf || (q > cap_r) || (d_r == '0)) ? cap_r : q;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/csf_log2.sv */
// Serial log2 of a nonzero value in Q.16: leading-bit search one shift per cycle,
// then one mantissa squaring per fraction bit. Depends on csf_pkg.
module csf_log2 #(
  parameter int LOG_STEPS = csf_pkg::LOG_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [csf_pkg::MD_W-1:0]    x_in,
  output logic                        done,
  output logic [LOG_STEPS+6:0]        result
);

  localparam int W  = csf_pkg::MD_W;
  localparam int KW = $clog2(W);
  localparam int SW = $clog2(LOG_STEPS);
  localparam logic [SW-1:0] STEP_LAST = SW'(LOG_STEPS - 1);

  typedef enum logic [1:0] {S_IDLE, S_NORM, S_SQ, S_FIN} lg_state_t;

  lg_state_t            state;
  logic [W-1:0]         x;
  logic [KW-1:0]        k;
  logic [30:0]          z;
  logic [LOG_STEPS-1:0] f;
  logic [SW-1:0]        step;

  logic [61:0]          sq;
  logic [31:0]          zz;
  logic [6:0]           k_rel;

  always_comb begin
    sq    = z * z;
    zz    = sq[61:30];
    k_rel = {1'b0, k} - 7'd16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x     <= x_in;
            k     <= KW'(W - 1);
            f     <= '0;
            state <= S_NORM;
          end
        end
        // shift until the leading one reaches the top
        S_NORM: begin
          if (x[W-1]) begin
            z     <= x[W-1:W-31];
            step  <= '0;
            state <= S_SQ;
          end else begin
            x <= {x[W-2:0], 1'b0};
            k <= k - 1'b1;
          end
        end
        // square the Q1.30 mantissa, take one fraction bit
        S_SQ: begin
          z    <= zz[31] ? zz[31:1] : zz[30:0];
          f    <= {f[LOG_STEPS-2:0], zz[31]};
          step <= step + 1'b1;
          if (step == STEP_LAST) state <= S_FIN;
        end
        S_FIN: begin
          result <= {k_rel, f};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* bench/cash_statistic_template_fit_sum_tb.sv */
// Self-checking bench for cash_statistic_template_fit_sum: random and directed
// histogram passes, checked against a bit-exact predictor of the fit sum.
// Depends on csf_pkg and the RTL of the block only.
module cash_statistic_template_fit_sum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LSTEPS = csf_pkg::LOG_STEPS_DEF;
  localparam int BIN_SETTLE = 3200;        // longer than the worst bin
  localparam longint CYCLE_LIMIT = 40000000;
  localparam int RANDOM_BINS = 2000;
  localparam int HOLD_CYCLES = 30000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  csf_pkg::bin_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  csf_pkg::q_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [csf_pkg::CFG_IDX_W-1:0] cfg_index = csf_pkg::CFG_SIGNAL_YIELD;
  logic [csf_pkg::TPL_W-1:0] cfg_data = '0;

  cash_statistic_template_fit_sum uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: registers, accumulator and flag
  logic [63:0] sig_yield_m, bkg_yield_m, sig_total_m, bkg_total_m;
  logic [65:0] q_acc_m;
  logic sat_m;
  csf_pkg::q_out_t q_expected[$];

  int errors = 0;
  int bins_sent = 0;
  int passes_checked = 0;
  int overflow_seen = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  longint cycles = 0;

  // floor(a*b/d) limited to cap; zero divisor gives cap
  function automatic logic [63:0] fit_muldiv(input logic [63:0] a, b, d, cap);
    logic [127:0] prod, quo;
    if (d == 0) return cap;
    prod = {64'd0, a} * {64'd0, b};
    quo = prod / {64'd0, d};
    if (quo > {64'd0, cap}) return cap;
    return quo[63:0];
  endfunction

  // log2 of a positive Q.16 value, LSTEPS fraction bits by squaring
  function automatic longint fit_log2(input logic [63:0] x);
    int k;
    logic [63:0] z, f;
    k = 63;
    while (k > 0 && !x[k]) k--;
    z = (k >= 30) ? (x >> (k - 30)) : (x << (30 - k));
    f = '0;
    for (int i = 0; i < LSTEPS; i++) begin
      z = (z * z) >> 30;
      f = f << 1;
      if (z >= 64'h8000_0000) begin
        z = z >> 1;
        f[0] = 1'b1;
      end
    end
    return longint'(k - 16) * (longint'(1) <<< LSTEPS) + longint'(f);
  endfunction

  // One Cash term E - O + O*ln(O/E), clamped at zero
  function automatic logic [63:0] cash_contrib(input logic [63:0] obs, expv);
    longint d, t;
    logic [63:0] mag, lmag, p;
    if (obs == 0 || expv == 0) return '0;
    d = fit_log2(obs) - fit_log2(expv);
    mag = (d < 0) ? -d : d;
    lmag = fit_muldiv(mag, csf_pkg::LN2_Q32, 64'd1 << (LSTEPS + 16), csf_pkg::CAP62);
    p = fit_muldiv(obs, lmag, csf_pkg::Q16_ONE, csf_pkg::CAP62);
    t = longint'(expv) - longint'(obs);
    t = (d < 0) ? t - longint'(p) : t + longint'(p);
    return (t > 0) ? t : '0;
  endfunction

  // Advance the predicted accumulator by one bin; queue Q on the last bin
  task automatic predict_bin(input csf_pkg::bin_in_t b);
    logic [63:0] u1, u2, v1, v2, mu0, vr, m, nq, tot, den, e1, e2;
    u1 = '0; u2 = '0; v1 = '0; v2 = '0;
    if (sig_total_m != 0) begin
      u1 = fit_muldiv(sig_yield_m, 64'(b.signal_bin), sig_total_m, 64'(csf_pkg::SAT48));
      v1 = fit_muldiv(sig_yield_m, u1, sig_total_m, 64'(csf_pkg::SAT48));
    end
    if (bkg_total_m != 0) begin
      u2 = fit_muldiv(bkg_yield_m, 64'(b.background_bin), bkg_total_m, 64'(csf_pkg::SAT48));
      v2 = fit_muldiv(bkg_yield_m, u2, bkg_total_m, 64'(csf_pkg::SAT48));
    end
    mu0 = (u1 + u2 > 64'(csf_pkg::SAT48)) ? 64'(csf_pkg::SAT48) : u1 + u2;
    vr = (v1 + v2 > 64'(csf_pkg::SAT48)) ? 64'(csf_pkg::SAT48) : v1 + v2;
    if (mu0 != 0 && vr != 0) begin
      m = fit_muldiv(mu0, mu0, vr, 64'(csf_pkg::SAT48));
      nq = 64'(b.observed_count) << 16;
      tot = nq + m;
      den = vr + mu0;
      e1 = fit_muldiv(tot, vr, den, tot);
      e2 = fit_muldiv(tot, mu0, den, tot);
      q_acc_m = q_acc_m + 66'(cash_contrib(nq, e1)) + 66'(cash_contrib(m, e2));
      if (q_acc_m > 66'(csf_pkg::SAT48)) begin
        q_acc_m = 66'(csf_pkg::SAT48);
        sat_m = 1'b1;
      end
    end
    if (b.last_bin) begin
      q_expected.push_back('{q_value: q_acc_m[47:0], overflow: sat_m});
      q_acc_m = '0;
      sat_m = 1'b0;
    end
  endtask

  // Write all four registers in back-to-back transfers
  task automatic set_config(input logic [31:0] y1, y2, input logic [39:0] s1, s2);
    logic [39:0] vals[4];
    logic [csf_pkg::CFG_IDX_W-1:0] idx[4];
    vals = '{40'(y1), 40'(y2), s1, s2};
    idx = '{csf_pkg::CFG_SIGNAL_YIELD, csf_pkg::CFG_BACKGROUND_YIELD,
            csf_pkg::CFG_SIGNAL_TOTAL, csf_pkg::CFG_BACKGROUND_TOTAL};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    sig_yield_m = 64'(y1);
    bkg_yield_m = 64'(y2);
    sig_total_m = 64'(s1);
    bkg_total_m = 64'(s2);
  endtask

  // Offer one bin, with a random gap first; valid stays high after the transfer
  task automatic send_bin(input csf_pkg::bin_in_t b);
    int gap;
    gap = (send_idle && $urandom_range(0, 99) < 32) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    predict_bin(b);
    bins_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the last bin finish
  task automatic drain_results();
    in_valid <= 1'b0;
    while (q_expected.size() != 0) @(posedge clk);
    repeat (BIN_SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return 32'($urandom_range(0, 8)) << 16;
      default: return $urandom_range(0, 65535) + (32'($urandom_range(0, 64)) << 16);
    endcase
  endfunction

  function automatic csf_pkg::bin_in_t rand_bin(input bit last);
    csf_pkg::bin_in_t b;
    case ($urandom_range(0, 3))
      0: b.observed_count = 20'($urandom);
      1: b.observed_count = 20'($urandom >> $urandom_range(0, 19));
      default: b.observed_count = 20'($urandom_range(0, 30));
    endcase
    b.signal_bin = rand_q16();
    b.background_bin = rand_q16();
    b.last_bin = last;
    return b;
  endfunction

  function automatic logic [39:0] rand_total();
    return {8'($urandom_range(0, 255)), 32'($urandom)} >> $urandom_range(0, 39);
  endfunction

  // Send one histogram of random bins with the given length
  task automatic send_histogram(input int len);
    for (int i = 0; i < len; i++) send_bin(rand_bin(i == len - 1));
  endtask

  function automatic csf_pkg::bin_in_t mk_bin(input logic [19:0] n,
                                              input logic [31:0] sg, bg,
                                              input bit last);
    return '{observed_count: n, signal_bin: sg, background_bin: bg, last_bin: last};
  endfunction

  // Extremes and special cases with hand-picked registers
  task automatic test_directed();
    // zero yields after reset: zero expectation everywhere
    send_bin(mk_bin(20'd7, 32'h0001_0000, 32'h0002_0000, 1'b1));
    drain_results();
    set_config(32'h0001_0000, 32'h0001_0000, csf_pkg::TOTAL_ONE, csf_pkg::TOTAL_ONE);
    send_bin(mk_bin(20'd0, 32'd0, 32'd0, 1'b0));
    send_bin(mk_bin(20'd5, 32'h0003_0000, 32'h0002_0000, 1'b0));
    send_bin(mk_bin(20'd0, 32'h0001_0000, 32'h0001_0000, 1'b0));
    send_bin(mk_bin(20'd1, 32'd1, 32'd0, 1'b0));
    send_bin(mk_bin(20'hFFFFF, 32'd0, 32'd1, 1'b1));
    send_bin(mk_bin(20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    drain_results();
    // tiny yield: nonzero expectation, variance rounds to zero
    set_config(32'd1, 32'd0, csf_pkg::TOTAL_ONE, csf_pkg::TOTAL_ONE);
    send_bin(mk_bin(20'd3, 32'd6553600, 32'h0001_0000, 1'b1));
    drain_results();
    // zero totals drop both templates
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'd0, 40'd0);
    send_bin(mk_bin(20'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    drain_results();
    set_config(32'h0002_0000, 32'h0003_0000, 40'd0, 40'h00_0004_0000);
    send_bin(mk_bin(20'd4, 32'h0001_8000, 32'h0002_0000, 1'b1));
    drain_results();
    // huge yields over minimal totals: accumulator saturates
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'd1, 40'd1);
    send_bin(mk_bin(20'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_bin(mk_bin(20'hFFFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0));
    send_bin(mk_bin(20'd2, 32'h8000_0000, 32'h0000_0001, 1'b1));
    drain_results();
    set_config(32'h0000_0001, 32'h0000_0001, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
    send_bin(mk_bin(20'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    drain_results();
  endtask

  // Random registers per phase, random histograms within each phase
  task automatic test_random_fits();
    int target;
    target = bins_sent + RANDOM_BINS;
    while (bins_sent < target) begin
      set_config(rand_q16(), rand_q16(), rand_total(), rand_total());
      // one phase in five runs with no idling on either side
      send_idle = ($urandom_range(0, 4) != 0);
      recv_idle = send_idle;
      for (int h = 0; h < 6; h++) send_histogram($urandom_range(1, 20));
      drain_results();
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Receiver holds off long while the sender keeps offering bins
  task automatic test_backpressure();
    set_config(32'h0001_0000, 32'h0002_0000, 40'h00_0010_0000, 40'h00_0020_0000);
    hold_req = !hold_req;
    for (int h = 0; h < 8; h++) send_histogram($urandom_range(1, 3));
    drain_results();
  endtask

  // Sender pauses mid-stream until every result has come
  task automatic test_sender_pause();
    send_histogram(5);
    in_valid <= 1'b0;
    while (q_expected.size() != 0) @(posedge clk);
    send_histogram(4);
    drain_results();
  endtask

  // Receiver stall: long hold-off on request, else random idling
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= recv_idle && ($urandom_range(0, 99) < 32);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (q_expected.size() == 0) begin
        $error("unexpected result q_value=%h overflow=%b", out_data.q_value, out_data.overflow);
        errors++;
      end else begin
        if (out_data.q_value !== q_expected[0].q_value) begin
          $error("q_value expected %h actual %h", q_expected[0].q_value, out_data.q_value);
          errors++;
        end
        if (out_data.overflow !== q_expected[0].overflow) begin
          $error("overflow expected %b actual %b", q_expected[0].overflow, out_data.overflow);
          errors++;
        end
        if (q_expected[0].overflow) overflow_seen++;
        passes_checked++;
        void'(q_expected.pop_front());
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sig_yield_m = '0;
    bkg_yield_m = '0;
    sig_total_m = 64'(csf_pkg::TOTAL_ONE);
    bkg_total_m = 64'(csf_pkg::TOTAL_ONE);
    q_acc_m = '0;
    sat_m = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_sender_pause();
    test_random_fits();
    if (q_expected.size() != 0) begin
      $error("%0d expected results never arrived", q_expected.size());
      errors++;
    end
    $display("Sent %0d bins, checked %0d histogram sums (%0d saturated)",
             bins_sent, passes_checked, overflow_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
